// File: rtl/nrt_pkg.sv
`default_nettype none
package nrt_pkg;

    localparam int CHUNK_BITS    = 64;
    localparam int SENDER_BITS   = 16;
    localparam int TID_BITS      = 16;
    localparam int IN_DATA_BITS  = 80;
    localparam int IN_USER_BITS  = 3;
    localparam int OUT_DATA_BITS = 24;

    localparam logic [1:0] KIND_REG  = 2'd0;
    localparam logic [1:0] KIND_LOOK = 2'd1;

    localparam logic [1:0] OP_REG  = 2'd0;
    localparam logic [1:0] OP_LOOK = 2'd1;
    localparam logic [1:0] OP_ERR  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_GENERIC = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NONAME  = 2'd3;

    typedef struct packed {
        logic [TID_BITS-1:0] task_id;
        logic [1:0]          status;
    } t_result;

endpackage
`default_nettype wire

// File: rtl/nrt_ram.sv
`default_nettype none
module nrt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/nrt_fifo.sv
`default_nettype none
module nrt_fifo #(
    parameter int WIDTH = 274
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);
    // two-entry request queue
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop && o_full) == 1'b0 |=> r_cnt != 2'd3)
        else $error("request queue count out of range");
`endif
endmodule
`default_nettype wire

// File: rtl/nrt_front.sv
`default_nettype none
module nrt_front #(
    parameter int NAME_WORDS = 4,
    parameter int ID_BITS    = 16,
    localparam int REQ_BITS  = 2 + ID_BITS + NAME_WORDS * nrt_pkg::CHUNK_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_accept,
    input  wire logic [nrt_pkg::CHUNK_BITS-1:0]       i_chunk,
    input  wire logic                                 i_last,
    input  wire logic [1:0]                           i_kind,
    input  wire logic                                 i_size_ok,
    input  wire logic [nrt_pkg::SENDER_BITS-1:0]      i_sender,
    output logic                                      o_push,
    output logic      [REQ_BITS-1:0]                  o_req
);
    localparam int NB       = NAME_WORDS * nrt_pkg::CHUNK_BITS;
    localparam int PW       = $clog2(NAME_WORDS + 1);

    logic [NB-1:0]      r_words;
    logic [PW-1:0]      r_pos;
    logic [NB-1:0]      n_name;
    logic [1:0]         op;
    logic [31:0]        sender_ext;
    logic [ID_BITS-1:0] id;

    always_comb begin
        n_name = r_words;
        if (r_pos < PW'(NAME_WORDS)) begin
            n_name[r_pos * nrt_pkg::CHUNK_BITS +: nrt_pkg::CHUNK_BITS] = i_chunk;
        end
    end

    always_comb begin
        if (!i_size_ok) begin
            op = nrt_pkg::OP_ERR;
        end else begin
            unique case (i_kind)
                nrt_pkg::KIND_REG:  op = nrt_pkg::OP_REG;
                nrt_pkg::KIND_LOOK: op = nrt_pkg::OP_LOOK;
                default:            op = nrt_pkg::OP_ERR;
            endcase
        end
    end

    assign sender_ext = 32'(i_sender);
    assign id         = sender_ext[ID_BITS-1:0];
    assign o_push     = i_accept && i_last;
    assign o_req      = {op, id, n_name};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= '0;
            r_pos   <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_words <= '0;
                r_pos   <= '0;
            end else begin
                r_words <= n_name;
                if (r_pos < PW'(NAME_WORDS)) begin
                    r_pos <= r_pos + PW'(1);
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/nrt_back.sv
`default_nettype none
module nrt_back #(
    parameter int TABLE_ENTRIES = 256,
    parameter int NAME_WORDS    = 4,
    parameter int ID_BITS       = 16,
    localparam int REQ_BITS     = 2 + ID_BITS + NAME_WORDS * nrt_pkg::CHUNK_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_empty,
    input  wire logic [REQ_BITS-1:0]   i_req,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output nrt_pkg::t_result           o_res
);
    localparam int CB       = nrt_pkg::CHUNK_BITS;
    localparam int NB       = NAME_WORDS * CB;
    localparam int EW       = $clog2(TABLE_ENTRIES);
    localparam int CW       = $clog2(TABLE_ENTRIES + 1);
    localparam int WW       = (NAME_WORDS > 1) ? $clog2(NAME_WORDS) : 1;
    localparam int NAW      = $clog2(TABLE_ENTRIES * NAME_WORDS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_IDRD   = 3'd2;
    localparam logic [2:0] S_APPEND = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [1:0]          r_op;
    logic [ID_BITS-1:0]  r_id;
    logic [NB-1:0]       r_name;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_ei;
    logic [WW-1:0]       r_wi;
    logic [NAW:0]        r_na;
    logic                r_pv;
    logic [EW-1:0]       r_pe;
    logic [WW-1:0]       r_pw;
    logic                r_acc;
    logic [1:0]          r_rstat;
    logic [15:0]         r_rtid;
    logic                r_ov;
    nrt_pkg::t_result    r_ores;

    logic [CB-1:0]       nm_rdata;
    logic                nm_we;
    logic [ID_BITS-1:0]  id_rdata;
    logic                id_we;
    logic [EW-1:0]       id_waddr;
    logic [31:0]         id_ext;

    logic                issue;
    logic                eqw;
    logic                acc;
    logic                found;
    logic                notfound;
    logic                wi_last;
    logic                load;

    nrt_ram #(.WIDTH(CB), .DEPTH(TABLE_ENTRIES * NAME_WORDS)) u_names (
        .i_clk   (i_clk),
        .i_we    (nm_we),
        .i_waddr (r_na[NAW-1:0]),
        .i_wdata (r_name[r_wi * CB +: CB]),
        .i_raddr (r_na[NAW-1:0]),
        .o_rdata (nm_rdata)
    );

    nrt_ram #(.WIDTH(ID_BITS), .DEPTH(TABLE_ENTRIES)) u_ids (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (id_waddr),
        .i_wdata (r_id),
        .i_raddr (r_pe),
        .o_rdata (id_rdata)
    );

    assign issue    = (r_state == S_SCAN) && (r_ei != r_count);
    assign eqw      = (nm_rdata == r_name[r_pw * CB +: CB]);
    assign acc      = ((r_pw == '0) || r_acc) && eqw;
    assign found    = (r_state == S_SCAN) && r_pv && acc && (r_pw == WW'(NAME_WORDS - 1));
    assign notfound = (r_state == S_SCAN) && !issue && !r_pv;
    assign wi_last  = (r_wi == WW'(NAME_WORDS - 1));
    assign nm_we    = (r_state == S_APPEND);
    assign id_we    = (found && (r_op == nrt_pkg::OP_REG)) || ((r_state == S_APPEND) && wi_last);
    assign id_waddr = (r_state == S_APPEND) ? r_count[EW-1:0] : r_pe;
    assign id_ext   = 32'(id_rdata);
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign load     = (r_state == S_DONE) && (!r_ov || i_ready);
    assign o_valid  = r_ov;
    assign o_res    = r_ores;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    if (i_req[REQ_BITS-1 -: 2] == nrt_pkg::OP_REG
                        || i_req[REQ_BITS-1 -: 2] == nrt_pkg::OP_LOOK) begin
                        if (i_req[REQ_BITS-1 -: 2] == nrt_pkg::OP_REG
                            && r_count == CW'(TABLE_ENTRIES)) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (found) begin
                    n_state = (r_op == nrt_pkg::OP_LOOK) ? S_IDRD : S_DONE;
                end else if (notfound) begin
                    n_state = (r_op == nrt_pkg::OP_REG) ? S_APPEND : S_DONE;
                end
            end
            S_IDRD:   n_state = S_DONE;
            S_APPEND: begin
                if (wi_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op   <= i_req[REQ_BITS-1 -: 2];
            r_id   <= i_req[NB +: ID_BITS];
            r_name <= i_req[NB-1:0];
        end
        if (r_pv) begin
            r_acc <= acc;
        end
        if (issue) begin
            r_pe <= r_ei[EW-1:0];
            r_pw <= r_wi;
        end
        if (load) begin
            r_ores.status  <= r_rstat;
            r_ores.task_id <= r_rtid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ei    <= '0;
            r_wi    <= '0;
            r_na    <= '0;
            r_pv    <= 1'b0;
            r_rstat <= nrt_pkg::ST_OK;
            r_rtid  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= issue && !found;
            if (o_pop) begin
                r_ei   <= '0;
                r_wi   <= '0;
                r_na   <= '0;
                r_rtid <= '0;
                if (i_req[REQ_BITS-1 -: 2] == nrt_pkg::OP_REG
                    && r_count == CW'(TABLE_ENTRIES)) begin
                    r_rstat <= nrt_pkg::ST_FULL;
                end else if (i_req[REQ_BITS-1 -: 2] == nrt_pkg::OP_REG
                             || i_req[REQ_BITS-1 -: 2] == nrt_pkg::OP_LOOK) begin
                    r_rstat <= nrt_pkg::ST_OK;
                end else begin
                    r_rstat <= nrt_pkg::ST_GENERIC;
                end
            end
            if (issue || r_state == S_APPEND) begin
                r_na <= r_na + (NAW+1)'(1);
                r_wi <= wi_last ? '0 : r_wi + WW'(1);
            end
            if (issue && wi_last) begin
                r_ei <= r_ei + CW'(1);
            end
            if (notfound && r_op == nrt_pkg::OP_LOOK) begin
                r_rstat <= nrt_pkg::ST_NONAME;
            end
            if (r_state == S_IDRD) begin
                r_rtid <= id_ext[15:0];
            end
            if (r_state == S_APPEND && wi_last) begin
                r_count <= r_count + CW'(1);
            end
            if (load) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("entry count beyond table size");
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_APPEND |-> r_count < CW'(TABLE_ENTRIES) && r_op == nrt_pkg::OP_REG)
        else $error("append without room or on a lookup");
    a_tid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_ores.status != nrt_pkg::ST_OK |-> r_ores.task_id == '0)
        else $error("nonzero task id on failed request");
`endif
endmodule
`default_nettype wire

// File: rtl/name_registry_table_top.sv
// Name registry: maps names of NAME_WORDS 64-bit words to task ids, up to TABLE_ENTRIES entries.
// Each name chunk is one input item and is taken while the two-entry request
// queue has room; the item with tlast set closes the request. The back end then scans the
// name memory through its single read port, one word per cycle, and writes the name into
// a new entry word by word when a new name is appended.
// One result item comes out per request; the table needs no clearing pass after reset.
`default_nettype none
module name_registry_table_top #(
    parameter int TABLE_ENTRIES = 256,
    parameter int NAME_WORDS    = 4,
    parameter int ID_BITS       = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // [63:0] name_chunk, [79:64] sender_id
    input  wire logic [nrt_pkg::IN_DATA_BITS-1:0]    i_s_axis_tdata,
    // [1:0] kind, [2] size_ok
    input  wire logic [nrt_pkg::IN_USER_BITS-1:0]    i_s_axis_tuser,
    input  wire logic                                i_s_axis_tlast,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [1:0] status, [17:2] task_id, [23:18] zero
    output logic      [nrt_pkg::OUT_DATA_BITS-1:0]   o_m_axis_tdata
);
    localparam int REQ_BITS = 2 + ID_BITS + NAME_WORDS * nrt_pkg::CHUNK_BITS;

    logic                  accept;
    logic                  push;
    logic [REQ_BITS-1:0]   req_in;
    logic [REQ_BITS-1:0]   req_out;
    logic                  full;
    logic                  empty;
    logic                  pop;
    nrt_pkg::t_result      res;

    assign o_s_axis_tready = !full;
    assign accept          = i_s_axis_tvalid && !full;
    assign o_m_axis_tdata  = {6'b0, res};

    nrt_front #(.NAME_WORDS(NAME_WORDS), .ID_BITS(ID_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_chunk   (i_s_axis_tdata[63:0]),
        .i_last    (i_s_axis_tlast),
        .i_kind    (i_s_axis_tuser[1:0]),
        .i_size_ok (i_s_axis_tuser[2]),
        .i_sender  (i_s_axis_tdata[79:64]),
        .o_push    (push),
        .o_req     (req_in)
    );

    nrt_fifo #(.WIDTH(REQ_BITS)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (req_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (req_out),
        .o_empty (empty)
    );

    nrt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NAME_WORDS    (NAME_WORDS),
        .ID_BITS       (ID_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_req   (req_out),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );
endmodule
`default_nettype wire

// File: verif/name_registry_table_top_tb.sv
`timescale 1ns / 100ps

module name_registry_table_top_tb;

    localparam int TABLE_ENTRIES = 256;
    localparam int NAME_WORDS    = 4;
    localparam int ID_BITS       = 16;
    localparam int NAME_BITS     = NAME_WORDS * nrt_pkg::CHUNK_BITS;
    localparam int ITEM_TARGET   = 1650;
    localparam int IDLE_LIMIT    = 8000;
    // one full-table scan plus append and pipeline slack
    localparam int DRAIN_CYCLES  = TABLE_ENTRIES * NAME_WORDS + 100;

    localparam logic [1:0] KIND_BAD2 = 2'd2;
    localparam logic [1:0] KIND_BAD3 = 2'd3;

    typedef struct {
        logic [nrt_pkg::CHUNK_BITS-1:0]  chunk;
        logic [nrt_pkg::SENDER_BITS-1:0] sender;
        logic [1:0]                      kind;
        logic                            size_ok;
        logic                            last;
        bit                              hold;
    } t_chunk_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    // [63:0] name_chunk, [79:64] sender_id
    logic [nrt_pkg::IN_DATA_BITS-1:0] i_s_axis_tdata = '0;
    // [1:0] kind, [2] size_ok
    logic [nrt_pkg::IN_USER_BITS-1:0] i_s_axis_tuser = '0;
    logic i_s_axis_tlast = 1'b0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    // [1:0] status, [17:2] task_id, [23:18] zero
    logic [nrt_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata;

    name_registry_table_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .NAME_WORDS   (NAME_WORDS),
        .ID_BITS      (ID_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [NAME_BITS-1:0]         reg_names [TABLE_ENTRIES];
    logic [nrt_pkg::TID_BITS-1:0] reg_ids [TABLE_ENTRIES];
    int unsigned                  reg_count = 0;
    logic [NAME_BITS-1:0]         asm_name = '0;
    int unsigned                  asm_pos = 0;

    nrt_pkg::t_result      expected_replies[$];
    t_chunk_item           chunk_q[$];
    logic [NAME_BITS-1:0]  name_pool[$];

    int unsigned status_seen[4] = '{0, 0, 0, 0};
    int unsigned items_taken = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned tx_gap = 0, tx_calm = 0, rx_stall = 0, rx_calm = 0;
    bit          chunk_taken = 1'b0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int unsigned find_name(input logic [NAME_BITS-1:0] nm);
        for (int unsigned i = 0; i < reg_count; i++) begin
            if (reg_names[i] == nm)
                return i;
        end
        return reg_count;
    endfunction

    task automatic resolve_chunk(input logic [nrt_pkg::CHUNK_BITS-1:0] chunk,
                                 input logic [nrt_pkg::SENDER_BITS-1:0] sender,
                                 input logic [1:0] kind, input logic size_ok,
                                 input logic last);
        nrt_pkg::t_result res;
        int unsigned      idx;
        if (asm_pos < NAME_WORDS) begin
            asm_name[asm_pos*nrt_pkg::CHUNK_BITS +: nrt_pkg::CHUNK_BITS] = chunk;
            asm_pos++;
        end
        if (last) begin
            res.task_id = '0;
            if (!size_ok) begin
                res.status = nrt_pkg::ST_GENERIC;
            end else if (kind == nrt_pkg::KIND_REG) begin
                if (reg_count >= TABLE_ENTRIES) begin
                    res.status = nrt_pkg::ST_FULL;
                end else begin
                    idx = find_name(asm_name);
                    if (idx == reg_count) begin
                        reg_names[idx] = asm_name;
                        reg_count++;
                    end
                    reg_ids[idx] = sender[ID_BITS-1:0];
                    res.status = nrt_pkg::ST_OK;
                end
            end else if (kind == nrt_pkg::KIND_LOOK) begin
                idx = find_name(asm_name);
                if (idx < reg_count) begin
                    res.status = nrt_pkg::ST_OK;
                    res.task_id = reg_ids[idx];
                end else begin
                    res.status = nrt_pkg::ST_NONAME;
                end
            end else begin
                res.status = nrt_pkg::ST_GENERIC;
            end
            asm_name = '0;
            asm_pos = 0;
            expected_replies.push_back(res);
            status_seen[res.status]++;
        end
    endtask

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    function automatic int unsigned used_words(input logic [NAME_BITS-1:0] nm);
        int unsigned u;
        u = 1;
        for (int unsigned i = 1; i < NAME_WORDS; i++) begin
            if (nm[i*nrt_pkg::CHUNK_BITS +: nrt_pkg::CHUNK_BITS] != '0)
                u = i + 1;
        end
        return u;
    endfunction

    function automatic logic [NAME_BITS-1:0] fresh_name();
        logic [NAME_BITS-1:0] nm;
        int unsigned          nw;
        int unsigned          r;
        nm = '0;
        nw = $urandom_range(1, NAME_WORDS);
        for (int unsigned i = 0; i < nw; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                nm[i*nrt_pkg::CHUNK_BITS +: nrt_pkg::CHUNK_BITS] = '0;
            else if (r == 1)
                nm[i*nrt_pkg::CHUNK_BITS +: nrt_pkg::CHUNK_BITS] = '1;
            else
                nm[i*nrt_pkg::CHUNK_BITS +: nrt_pkg::CHUNK_BITS] = {$urandom, $urandom};
        end
        return nm;
    endfunction

    // chunks past NAME_WORDS carry junk; fields on non-final chunks are junk too
    task automatic send_name(input logic [NAME_BITS-1:0] nm, input int unsigned n_sent,
                             input logic [1:0] kind,
                             input logic [nrt_pkg::SENDER_BITS-1:0] sender,
                             input logic size_ok, input bit hold);
        t_chunk_item it;
        for (int unsigned i = 0; i < n_sent; i++) begin
            it.chunk = (i < NAME_WORDS) ? nm[i*nrt_pkg::CHUNK_BITS +: nrt_pkg::CHUNK_BITS]
                                        : {$urandom, $urandom};
            it.last = (i == n_sent - 1);
            it.hold = hold && (i == 0);
            if (it.last) begin
                it.kind = kind;
                it.sender = sender;
                it.size_ok = size_ok;
            end else begin
                it.kind = 2'($urandom_range(0, 3));
                it.sender = 16'($urandom);
                it.size_ok = 1'($urandom_range(0, 1));
            end
            chunk_q.push_back(it);
        end
    endtask

    // sender
    always @(negedge i_clk) begin
        t_chunk_item cur;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && !chunk_taken) begin
                // item still waiting for tready
            end else if (tx_gap != 0) begin
                tx_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (chunk_q.size() != 0 &&
                         !(chunk_q[0].hold && expected_replies.size() != 0)) begin
                cur = chunk_q.pop_front();
                i_s_axis_tdata <= {cur.sender, cur.chunk};
                i_s_axis_tuser <= {cur.size_ok, cur.kind};
                i_s_axis_tlast <= cur.last;
                i_s_axis_tvalid <= 1'b1;
                if (tx_calm != 0) begin
                    tx_calm--;
                    tx_gap = 0;
                end else begin
                    tx_gap = idle_len();
                    if ($urandom_range(0, 99) == 0)
                        tx_calm = $urandom_range(20, 120);
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (rx_calm != 0)
                rx_calm--;
            else if ($urandom_range(0, 299) == 0)
                rx_calm = $urandom_range(100, 600);
            if (rx_stall != 0) begin
                rx_stall--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (rx_calm == 0)
                    rx_stall = idle_len();
            end
        end
    end

    // monitor, predictor hookup and watchdog
    always @(posedge i_clk) begin
        nrt_pkg::t_result want;
        nrt_pkg::t_result got;
        chunk_taken = 1'b0;
        if (i_rst_n) begin
            idle_cycles++;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                idle_cycles = 0;
                got = o_m_axis_tdata[nrt_pkg::TID_BITS+1:0];
                if (expected_replies.size() == 0) begin
                    report_mismatch($sformatf("result with none pending: status %0d id %h",
                                              got.status, got.task_id));
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status != want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  got.status, want.status));
                    if (got.task_id != want.task_id)
                        report_mismatch($sformatf("task_id %h, want %h",
                                                  got.task_id, want.task_id));
                end
                if (o_m_axis_tdata[nrt_pkg::OUT_DATA_BITS-1:nrt_pkg::TID_BITS+2] != '0)
                    report_mismatch($sformatf("pad bits %h not zero",
                        o_m_axis_tdata[nrt_pkg::OUT_DATA_BITS-1:nrt_pkg::TID_BITS+2]));
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                idle_cycles = 0;
                chunk_taken = 1'b1;
                items_taken++;
                resolve_chunk(i_s_axis_tdata[nrt_pkg::CHUNK_BITS-1:0],
                              i_s_axis_tdata[nrt_pkg::CHUNK_BITS +: nrt_pkg::SENDER_BITS],
                              i_s_axis_tuser[1:0], i_s_axis_tuser[2], i_s_axis_tlast);
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
                $display("name_registry_table_top_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        logic [NAME_BITS-1:0] nm;
        logic [NAME_BITS-1:0] ones1;
        logic [NAME_BITS-1:0] ones1_w1;
        logic [1:0]           kind;
        bit                   ok;
        bit                   hold;
        int unsigned          r, u, n_sent, req_no;

        ones1 = '0;
        ones1[nrt_pkg::CHUNK_BITS-1:0] = '1;
        ones1_w1 = ones1;
        ones1_w1[nrt_pkg::CHUNK_BITS] = 1'b1;

        // directed
        send_name('0, 1, nrt_pkg::KIND_LOOK, 16'h1234, 1'b1, 1'b0);       // empty table
        send_name(ones1, 1, nrt_pkg::KIND_REG, 16'hFFFF, 1'b1, 1'b0);
        send_name('0, NAME_WORDS, nrt_pkg::KIND_REG, 16'h0000, 1'b1, 1'b0); // all-zero name
        send_name(ones1, 1, nrt_pkg::KIND_LOOK, 16'($urandom), 1'b1, 1'b0);
        send_name(ones1, 1, nrt_pkg::KIND_REG, 16'h5A5A, 1'b1, 1'b0);     // update in place
        send_name(ones1, NAME_WORDS + 1, nrt_pkg::KIND_LOOK, 16'($urandom), 1'b1,
                  1'b0);                                                   // extra chunk
        send_name(ones1_w1, 2, nrt_pkg::KIND_LOOK, 16'($urandom), 1'b1, 1'b0); // word 1 differs
        send_name(ones1, 1, KIND_BAD2, 16'($urandom), 1'b1, 1'b0);
        send_name(ones1, 1, KIND_BAD3, 16'($urandom), 1'b1, 1'b0);
        send_name(ones1, 1, nrt_pkg::KIND_LOOK, 16'($urandom), 1'b0, 1'b0); // bad size wins
        send_name(ones1_w1, 2, nrt_pkg::KIND_REG, 16'($urandom), 1'b0, 1'b0); // must not store
        send_name(ones1_w1, 2, nrt_pkg::KIND_LOOK, 16'($urandom), 1'b1, 1'b0);
        send_name('0, 1, nrt_pkg::KIND_LOOK, 16'($urandom), 1'b1, 1'b0);
        name_pool.push_back('0);
        name_pool.push_back(ones1);

        // random: mostly well-formed requests, table fills partway through
        req_no = 0;
        while (chunk_q.size() < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            ok = 1'b1;
            kind = nrt_pkg::KIND_REG;
            hold = (req_no == 0) || ($urandom_range(0, 149) == 0);
            nm = name_pool[$urandom_range(0, name_pool.size() - 1)];
            if (r < 60) begin
                nm = fresh_name();
                name_pool.push_back(nm);
            end else if (r < 70) begin
                kind = nrt_pkg::KIND_REG;
            end else if (r < 86) begin
                kind = nrt_pkg::KIND_LOOK;
            end else if (r < 90) begin
                nm[$urandom_range(0, NAME_BITS - 1)] ^= 1'b1;
                kind = (r < 88) ? nrt_pkg::KIND_LOOK : nrt_pkg::KIND_REG;
            end else if (r < 92) begin
                nm = fresh_name();
                kind = nrt_pkg::KIND_LOOK;
            end else if (r < 96) begin
                kind = 2'($urandom_range(2, 3));
            end else begin
                ok = 1'b0;
                kind = 2'($urandom_range(0, 3));
            end
            u = used_words(nm);
            if ($urandom_range(0, 99) < 8)
                n_sent = NAME_WORDS + $urandom_range(1, 3);
            else
                n_sent = $urandom_range(u, NAME_WORDS);
            send_name(nm, n_sent, kind, 16'($urandom), ok, hold);
            req_no++;
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (chunk_q.size() != 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        while (expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d chunk items, %0d requests; table reached %0d of %0d entries",
                 items_taken, status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3],
                 reg_count, TABLE_ENTRIES);
        $display("statuses: ok %0d, generic error %0d, table full %0d, no such name %0d",
                 status_seen[nrt_pkg::ST_OK], status_seen[nrt_pkg::ST_GENERIC],
                 status_seen[nrt_pkg::ST_FULL], status_seen[nrt_pkg::ST_NONAME]);
        if (mismatch_count == 0) begin
            $display("name_registry_table_top_tb OK");
        end else begin
            $display("name_registry_table_top_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/nrt_pkg.sv
rtl/nrt_ram.sv
rtl/nrt_fifo.sv
rtl/nrt_front.sv
rtl/nrt_back.sv
rtl/name_registry_table_top.sv
verif/name_registry_table_top_tb.sv
